@@ src/cdar_pkg.sv @@
// Shared types, constants and helper functions for the captive DNS A responder.
// Used by cdar_ctrl, cdar_dpath, the top level and the checker; no dependencies.
package cdar_pkg;

  // default size of the packet store in bytes
  localparam int unsigned BUFFER_BYTES = 512;

  // fixed packet layout
  localparam int unsigned HDR_BYTES    = 12;
  localparam int unsigned QTAIL_BYTES  = 4;
  localparam int unsigned ANSWER_BYTES = 16;
  localparam int unsigned WORD_BYTES   = 8;

  // constant reply bytes
  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] TTL_LO   = 8'd60;
  localparam logic [7:0] RDLEN_LO = 8'h04;

  // result codes
  typedef enum logic [2:0] {
    OC_DATA     = 3'd0,
    OC_SHORT    = 3'd1,
    OC_QDCOUNT  = 3'd2,
    OC_OVERRUN  = 3'd3,
    OC_NOT_A    = 3'd4,
    OC_TOO_LONG = 3'd5
  } outcome_e;

  // controller states
  typedef enum logic [3:0] {
    ST_RX,
    ST_CHK,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_NAME_END,
    ST_TYPE_RD0,
    ST_TYPE_RD1,
    ST_TYPE_EV,
    ST_EMIT_RD,
    ST_EMIT_SH,
    ST_PUSH,
    ST_DROP
  } state_e;

  // packet store read address source
  typedef enum logic [1:0] {
    RD_P,
    RD_P1,
    RD_J
  } rd_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     accept;
    logic     p_init;
    logic     p_step;
    logic     p_inc;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     type_hi_cap;
    logic     j_init;
    logic     byte_shift;
    logic     push_word;
    logic     push_drop;
    logic     set_reason;
    outcome_e reason;
    logic     finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_short;
    logic qd_bad;
    logic p_ge_len;
    logic rd_zero;
    logic name_short;
    logic type_bad;
    logic too_long;
    logic last_byte;
    logic word_fill;
    logic j_done;
    logic out_free;
  } status_t;

  // byte k of the appended answer record
  function automatic logic [7:0] answer_byte(input logic [3:0] k, input logic [31:0] addr);
    logic [7:0] b;
    case (k) inside
      4'd0:                   b = PTR_HI;
      4'd1:                   b = PTR_LO;
      4'd3, 4'd5:             b = 8'h01;
      4'd9:                   b = TTL_LO;
      4'd11:                  b = RDLEN_LO;
      4'd12:                  b = addr[31:24];
      4'd13:                  b = addr[23:16];
      4'd14:                  b = addr[15:8];
      4'd15:                  b = addr[7:0];
      default:                b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ src/cdar_ctrl.sv @@
// Controller state machine of the captive DNS A responder.
// Depends on cdar_pkg for state, command and status types.
module cdar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  cdar_pkg::status_t status_i,
  output cdar_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);

  cdar_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdar_pkg::ST_RX;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdar_pkg::ST_RX: begin
        if (in_valid_i && in_last_i) state_d = cdar_pkg::ST_CHK;
      end
      cdar_pkg::ST_CHK: begin
        if (status_i.len_short || status_i.qd_bad) state_d = cdar_pkg::ST_DROP;
        else state_d = cdar_pkg::ST_WALK_RD;
      end
      cdar_pkg::ST_WALK_RD: begin
        if (status_i.p_ge_len) state_d = cdar_pkg::ST_DROP;
        else state_d = cdar_pkg::ST_WALK_EV;
      end
      cdar_pkg::ST_WALK_EV: begin
        if (status_i.rd_zero) state_d = cdar_pkg::ST_NAME_END;
        else state_d = cdar_pkg::ST_WALK_RD;
      end
      cdar_pkg::ST_NAME_END: begin
        if (status_i.name_short) state_d = cdar_pkg::ST_DROP;
        else state_d = cdar_pkg::ST_TYPE_RD0;
      end
      cdar_pkg::ST_TYPE_RD0: state_d = cdar_pkg::ST_TYPE_RD1;
      cdar_pkg::ST_TYPE_RD1: state_d = cdar_pkg::ST_TYPE_EV;
      cdar_pkg::ST_TYPE_EV: begin
        if (status_i.type_bad || status_i.too_long) state_d = cdar_pkg::ST_DROP;
        else state_d = cdar_pkg::ST_EMIT_RD;
      end
      cdar_pkg::ST_EMIT_RD: state_d = cdar_pkg::ST_EMIT_SH;
      cdar_pkg::ST_EMIT_SH: begin
        if (status_i.last_byte || status_i.word_fill) state_d = cdar_pkg::ST_PUSH;
        else state_d = cdar_pkg::ST_EMIT_RD;
      end
      cdar_pkg::ST_PUSH: begin
        if (status_i.out_free) begin
          if (status_i.j_done) state_d = cdar_pkg::ST_RX;
          else state_d = cdar_pkg::ST_EMIT_RD;
        end
      end
      cdar_pkg::ST_DROP: begin
        if (status_i.out_free) state_d = cdar_pkg::ST_RX;
      end
      default: state_d = cdar_pkg::ST_RX;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = cdar_pkg::RD_P;
    cmd_o.reason = cdar_pkg::OC_DATA;
    in_stall_o   = 1'b1;
    unique case (state_q)
      cdar_pkg::ST_RX: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      cdar_pkg::ST_CHK: begin
        cmd_o.p_init = 1'b1;
        if (status_i.len_short) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_SHORT;
        end else if (status_i.qd_bad) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_QDCOUNT;
        end
      end
      cdar_pkg::ST_WALK_RD: begin
        if (status_i.p_ge_len) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_OVERRUN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = cdar_pkg::RD_P;
        end
      end
      cdar_pkg::ST_WALK_EV: begin
        cmd_o.p_step = !status_i.rd_zero;
      end
      cdar_pkg::ST_NAME_END: begin
        if (status_i.name_short) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_OVERRUN;
        end else begin
          cmd_o.p_inc = 1'b1;
        end
      end
      cdar_pkg::ST_TYPE_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cdar_pkg::RD_P;
      end
      cdar_pkg::ST_TYPE_RD1: begin
        cmd_o.type_hi_cap = 1'b1;
        cmd_o.rd_en       = 1'b1;
        cmd_o.rd_sel      = cdar_pkg::RD_P1;
      end
      cdar_pkg::ST_TYPE_EV: begin
        if (status_i.type_bad) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_NOT_A;
        end else if (status_i.too_long) begin
          cmd_o.set_reason = 1'b1;
          cmd_o.reason     = cdar_pkg::OC_TOO_LONG;
        end else begin
          cmd_o.j_init = 1'b1;
        end
      end
      cdar_pkg::ST_EMIT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cdar_pkg::RD_J;
      end
      cdar_pkg::ST_EMIT_SH: begin
        cmd_o.byte_shift = 1'b1;
      end
      cdar_pkg::ST_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push_word = 1'b1;
          cmd_o.finish    = status_i.j_done;
        end
      end
      cdar_pkg::ST_DROP: begin
        if (status_i.out_free) begin
          cmd_o.push_drop = 1'b1;
          cmd_o.finish    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/cdar_dpath.sv @@
// Datapath of the captive DNS A responder: packet store, name walk pointer,
// reply word assembly, output register and address register. Depends on cdar_pkg.
module cdar_dpath #(
  parameter int unsigned BUFFER_BYTES = cdar_pkg::BUFFER_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdar_pkg::cmd_t    cmd_i,
  output cdar_pkg::status_t status_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [63:0]       reply_word_o,
  output logic [3:0]        word_bytes_o,
  output logic              reply_last_o,
  output logic [2:0]        outcome_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned PW = $clog2(BUFFER_BYTES + 257);
  localparam int unsigned SW = PW + 1;

  logic [7:0]         mem [BUFFER_BYTES];
  logic [CW-1:0]      count_q;
  logic [7:0]         qd_hi_q, qd_lo_q;
  logic [7:0]         rd_q;
  logic [AW-1:0]      rd_addr;
  logic [PW-1:0]      p_q;
  logic               type_hi_ok_q;
  logic [CW-1:0]      j_q;
  logic [3:0]         nbytes_q;
  logic [63:0]        word_q;
  cdar_pkg::outcome_e reason_q;
  logic [31:0]        answer_addr_q;
  logic               out_valid_q;
  logic [63:0]        out_word_q;
  logic [3:0]         out_bytes_q;
  logic               out_last_q;
  cdar_pkg::outcome_e out_outcome_q;

  logic [SW-1:0]      len_w, p_w, qend_w, total_w, j_w, ans_diff;
  logic [7:0]         cur_byte;
  logic               out_free;

  // widened values for compares
  assign len_w    = SW'(count_q);
  assign p_w      = SW'(p_q);
  assign j_w      = SW'(j_q);
  assign qend_w   = p_w + SW'(cdar_pkg::QTAIL_BYTES);
  assign total_w  = qend_w + SW'(cdar_pkg::ANSWER_BYTES);
  assign ans_diff = j_w - qend_w;
  assign out_free = !out_valid_q || !out_stall_i;

  // status toward the controller
  assign status_o.len_short  = len_w < SW'(cdar_pkg::HDR_BYTES);
  assign status_o.qd_bad     = !(qd_hi_q == 8'h00 && qd_lo_q == 8'h01);
  assign status_o.p_ge_len   = p_w >= len_w;
  assign status_o.rd_zero    = rd_q == 8'h00;
  assign status_o.name_short = (p_w + SW'(5)) > len_w;
  assign status_o.type_bad   = !(type_hi_ok_q && rd_q == 8'h01);
  assign status_o.too_long   = total_w > SW'(BUFFER_BYTES);
  assign status_o.last_byte  = (j_w + SW'(1)) == total_w;
  assign status_o.word_fill  = nbytes_q == 4'(cdar_pkg::WORD_BYTES - 1);
  assign status_o.j_done     = j_w == total_w;
  assign status_o.out_free   = out_free;

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      cdar_pkg::RD_P1: rd_addr = AW'(p_q + PW'(1));
      cdar_pkg::RD_J:  rd_addr = AW'(j_q);
      default:         rd_addr = AW'(p_q);
    endcase
  end

  // packet store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && count_q < CW'(BUFFER_BYTES)) begin
      mem[AW'(count_q)] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish) begin
      count_q <= '0;
    end else if (cmd_i.accept && count_q < CW'(BUFFER_BYTES)) begin
      count_q <= count_q + CW'(1);
    end
  end

  // question count bytes captured on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && count_q == CW'(4)) qd_hi_q <= rx_byte_i;
    if (cmd_i.accept && count_q == CW'(5)) qd_lo_q <= rx_byte_i;
  end

  // name walk pointer and type check
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_init) begin
      p_q <= PW'(cdar_pkg::HDR_BYTES);
    end else if (cmd_i.p_step) begin
      p_q <= p_q + PW'(rd_q) + PW'(1);
    end else if (cmd_i.p_inc) begin
      p_q <= p_q + PW'(1);
    end
    if (cmd_i.type_hi_cap) type_hi_ok_q <= rd_q == 8'h00;
    if (cmd_i.set_reason) reason_q <= cmd_i.reason;
  end

  // reply byte for position j
  always_comb begin
    cur_byte = 8'h00;
    if (j_w < qend_w) begin
      if (j_q == CW'(2)) cur_byte = cdar_pkg::FLAGS_HI;
      else if (j_q == CW'(3)) cur_byte = cdar_pkg::FLAGS_LO;
      else if (j_q == CW'(6)) cur_byte = 8'h00;
      else if (j_q == CW'(7)) cur_byte = 8'h01;
      else if (j_q >= CW'(8) && j_q < CW'(cdar_pkg::HDR_BYTES)) cur_byte = 8'h00;
      else cur_byte = rd_q;
    end else begin
      cur_byte = cdar_pkg::answer_byte(ans_diff[3:0], answer_addr_q);
    end
  end

  // word assembly, first byte in the top lane
  always_ff @(posedge clk_i) begin
    if (cmd_i.j_init || cmd_i.push_word) begin
      word_q   <= '0;
      nbytes_q <= '0;
    end else if (cmd_i.byte_shift) begin
      for (int k = 0; k < 8; k++) begin
        if (nbytes_q == 4'(k)) word_q[8*(7-k) +: 8] <= cur_byte;
      end
      nbytes_q <= nbytes_q + 4'd1;
    end
    if (cmd_i.j_init) begin
      j_q <= '0;
    end else if (cmd_i.byte_shift) begin
      j_q <= j_q + CW'(1);
    end
  end

  // answer address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_addr_q <= '0;
    end else if (cfg_valid_i) begin
      answer_addr_q <= cfg_data_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_word || cmd_i.push_drop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_word) begin
      out_word_q    <= word_q;
      out_bytes_q   <= nbytes_q;
      out_last_q    <= status_o.j_done;
      out_outcome_q <= cdar_pkg::OC_DATA;
    end else if (cmd_i.push_drop) begin
      out_word_q    <= '0;
      out_bytes_q   <= '0;
      out_last_q    <= 1'b1;
      out_outcome_q <= reason_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_word_o = out_word_q;
  assign word_bytes_o = out_bytes_q;
  assign reply_last_o = out_last_q;
  assign outcome_o    = out_outcome_q;

endmodule

@@ src/captive_dns_a_responder.sv @@
// Top level of the captive DNS A responder: controller plus datapath.
// Depends on cdar_pkg, cdar_ctrl and cdar_dpath.
//
// Usage: query bytes enter on the input channel (in_valid_i / in_stall_o),
// rx_last_i marks the final byte. Up to BUFFER_BYTES bytes are stored, the
// rest of an oversized datagram is dropped but its last flag still counts.
// After the last byte the block checks the query, walking the name one label
// per read and evaluate step through the single read port of the packet store.
// A good query yields the reply as 8-byte words on the output channel
// (out_valid_o / out_stall_i), reply_last_o on the final word; a bad one yields
// one drop result with the reason in outcome_o. Input takes one byte per cycle
// while receiving. From the last byte until the final result sits in the output
// register the input is stalled: the query is checked, then each reply byte is
// read and shifted in and each word pushed, all paced by the one store read
// port. A stalled receiver holds the output register and the word assembly
// waits behind it. The answer address is written on the cfg channel (always
// ready); the user must write it only while idle, the block does not enforce
// this. Reset clears the byte count, the controller, the output valid and the
// address register; the packet store itself needs no clearing.
module captive_dns_a_responder #(
  parameter int unsigned BUFFER_BYTES = cdar_pkg::BUFFER_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] reply_word_o,
  output logic [3:0]  word_bytes_o,
  output logic        reply_last_o,
  output logic [2:0]  outcome_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  cdar_pkg::cmd_t    cmd;
  cdar_pkg::status_t status;

  // configuration is taken at any time
  assign cfg_ready_o = 1'b1;

  // controller
  cdar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (rx_last_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath
  cdar_dpath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .rx_byte_i    (rx_byte_i),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .reply_word_o (reply_word_o),
    .word_bytes_o (word_bytes_o),
    .reply_last_o (reply_last_o),
    .outcome_o    (outcome_o)
  );

endmodule

@@ src/cdar_checker.sv @@
// Port level checker for the captive DNS A responder, bound to the top level.
// Depends on cdar_pkg for the result codes.
module cdar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  word_bytes_o,
  input logic        reply_last_o,
  input logic [2:0]  outcome_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // drop results are empty and close the datagram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != cdar_pkg::OC_DATA |-> word_bytes_o == 4'd0 && reply_last_o)
    else $error("drop result with data or without last");

  // reply data words carry one to eight bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == cdar_pkg::OC_DATA |-> word_bytes_o != 4'd0 && word_bytes_o <= 4'd8)
    else $error("reply word byte count out of range");

  // only the final reply word may be partial
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == cdar_pkg::OC_DATA && !reply_last_o |-> word_bytes_o == 4'd8)
    else $error("partial reply word before the last");

endmodule

bind captive_dns_a_responder cdar_checker u_cdar_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .word_bytes_o (word_bytes_o),
  .reply_last_o (reply_last_o),
  .outcome_o    (outcome_o)
);
